FILE: rtl/core/one_bit_quantizer_mean_recon_assert.svh
// ----------------------------------------------------------------------------
// One-bit quantizer assertion macros
// Shorthand for clocked concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ONE_BIT_QUANTIZER_MEAN_RECON_ASSERT_SVH
`define ONE_BIT_QUANTIZER_MEAN_RECON_ASSERT_SVH

// Assertion that is switched off while reset is held
`define OBQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked through reset as well
`define OBQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/obq_pkg.sv
// ----------------------------------------------------------------------------
// One-bit quantizer package
// Widths, field positions and defaults shared by the core and its checker.
// ----------------------------------------------------------------------------
package obq_pkg;

    localparam int SAMPLE_IN_WIDTH  = 16;
    localparam int SUM_WIDTH        = 32;
    localparam int NEG_MEAN_WIDTH   = 16;
    localparam int POS_MEAN_WIDTH   = 15;
    localparam int TDATA_WIDTH      = 1 + NEG_MEAN_WIDTH + POS_MEAN_WIDTH;

    // Result word layout, lowest bit up: code, neg_mean, pos_mean
    localparam int CODE_BIT         = 0;
    localparam int NEG_MEAN_LSB     = CODE_BIT + 1;
    localparam int NEG_MEAN_MSB     = NEG_MEAN_LSB + NEG_MEAN_WIDTH - 1;
    localparam int POS_MEAN_LSB     = NEG_MEAN_MSB + 1;

    localparam int DIV_STEP_WIDTH   = $clog2(SUM_WIDTH);

    localparam int DEF_MAX_LEN      = 65536;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Magnitude at which the non-positive mean pins to its most negative value
    localparam logic [SUM_WIDTH-1:0] NEG_MAG_LIMIT = SUM_WIDTH'(32768);
    localparam logic [NEG_MEAN_WIDTH-1:0] NEG_MEAN_MIN = {1'b1, {(NEG_MEAN_WIDTH-1){1'b0}}};
    localparam logic [POS_MEAN_WIDTH-1:0] POS_MEAN_MAX = {POS_MEAN_WIDTH{1'b1}};

endpackage

FILE: rtl/core/one_bit_quantizer_mean_recon.sv
// ----------------------------------------------------------------------------
// One-bit sign quantizer with conditional-mean reconstruction
// Emits a sign code per sample and, at the end of each block, the means of
// the positive and the non-positive samples.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one signed sample per request in s_tdata, with
//   s_tlast on the final sample of a block. The m_ channel returns one
//   result per request: code in m_tdata[0], and on the final result the
//   non-positive mean in m_tdata[16:1] and the positive mean in
//   m_tdata[31:17], with m_tuser flagging that the means are present.
//   m_tlast copies s_tlast.
//   A sample without s_tlast is folded into the running sums and its
//   result is registered in the cycle after acceptance; one such sample can
//   be taken every cycle while the receiver keeps up.
//   A final sample starts two passes of one shared restoring divider, one
//   quotient bit a cycle: each mean passes a load, the quotient steps and
//   a store. Its result is registered once the result register is free,
//   and s_tready stays low meanwhile. The sums and counts are then cleared
//   for the next block. Reset clears the sums, counts and output valid;
//   the block is ready as soon as reset ends. While a result waits on
//   m_tready, the result register holds and no new sample is taken.
// ----------------------------------------------------------------------------
module one_bit_quantizer_mean_recon #(
    parameter int MAX_LEN      = obq_pkg::DEF_MAX_LEN,
    parameter int SAMPLE_WIDTH = obq_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [obq_pkg::SAMPLE_IN_WIDTH-1:0] s_tdata,  // sample
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [obq_pkg::TDATA_WIDTH-1:0]    m_tdata,   // code, neg_mean, pos_mean
    output logic                               m_tuser,   // means_valid
    output logic                               m_tlast
);
    import obq_pkg::*;

    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int EXT_W = SUM_WIDTH + 1;
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_LEN);
    localparam logic [DIV_STEP_WIDTH-1:0] STEP_LAST = DIV_STEP_WIDTH'(SUM_WIDTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STORE,
        ST_PUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [SUM_WIDTH-1:0]        pos_sum_reg, pos_sum_next;
    logic [SUM_WIDTH-1:0]        neg_sum_reg, neg_sum_next;
    logic [CW-1:0]               pos_cnt_reg, pos_cnt_next;
    logic [CW-1:0]               neg_cnt_reg, neg_cnt_next;
    logic [SUM_WIDTH-1:0]        dvd_reg, dvd_next;
    logic [CW-1:0]               rem_reg, rem_next;
    logic [CW-1:0]               dvs_reg, dvs_next;
    logic [DIV_STEP_WIDTH-1:0]   step_reg, step_next;
    logic                        side_reg, side_next;
    logic                        code_reg, code_next;
    logic [NEG_MEAN_WIDTH-1:0]   neg_mean_reg, neg_mean_next;
    logic [POS_MEAN_WIDTH-1:0]   pos_mean_reg, pos_mean_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [TDATA_WIDTH-1:0]      m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;
    logic                        m_tlast_reg, m_tlast_next;

    logic [SAMPLE_IN_WIDTH+SAMPLE_WIDTH-1:0] tdata_wide;
    logic [SAMPLE_WIDTH-1:0]     raw_sample;
    logic signed [EXT_W-1:0]     sample_ext;
    logic                        is_pos;
    logic                        out_free;
    logic                        s_accept;
    logic [CW:0]                 rem_shift;
    logic [CW:0]                 rem_diff;

    function automatic logic [SUM_WIDTH-1:0] sat_add(
        input logic [SUM_WIDTH-1:0] acc,
        input logic [EXT_W-1:0]     inc
    );
        logic [EXT_W-1:0] total;
        total = {acc[SUM_WIDTH-1], acc} + inc;
        if (total[EXT_W-1] != total[SUM_WIDTH-1]) begin
            return total[EXT_W-1] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                  : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        return total[SUM_WIDTH-1:0];
    endfunction

    // Sign-extend from bit SAMPLE_WIDTH-1; bits above the port read as zero
    assign tdata_wide = {{SAMPLE_WIDTH{1'b0}}, s_tdata};
    assign raw_sample = tdata_wide[SAMPLE_WIDTH-1:0];
    assign sample_ext = EXT_W'($signed(raw_sample));
    assign is_pos     = !sample_ext[EXT_W-1] && (sample_ext != '0);

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign rem_shift = {rem_reg, dvd_reg[SUM_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        state_next    = state_reg;
        pos_sum_next  = pos_sum_reg;
        neg_sum_next  = neg_sum_reg;
        pos_cnt_next  = pos_cnt_reg;
        neg_cnt_next  = neg_cnt_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        step_next     = step_reg;
        side_next     = side_reg;
        code_next     = code_reg;
        neg_mean_next = neg_mean_reg;
        pos_mean_next = pos_mean_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // Drop samples of a side whose count is full
                    if (is_pos) begin
                        if (pos_cnt_reg < COUNT_LIMIT) begin
                            pos_sum_next = sat_add(pos_sum_reg, sample_ext);
                            pos_cnt_next = pos_cnt_reg + 1'b1;
                        end
                    end else begin
                        if (neg_cnt_reg < COUNT_LIMIT) begin
                            neg_sum_next = sat_add(neg_sum_reg, sample_ext);
                            neg_cnt_next = neg_cnt_reg + 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        code_next  = is_pos;
                        side_next  = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = TDATA_WIDTH'(is_pos);
                        m_tuser_next  = 1'b0;
                        m_tlast_next  = 1'b0;
                    end
                end
            end
            ST_LOAD: begin
                // Divide magnitudes; the non-positive sum is negated first
                dvd_next   = side_reg ? pos_sum_reg : ('0 - neg_sum_reg);
                dvs_next   = side_reg ? pos_cnt_reg : neg_cnt_reg;
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!rem_diff[CW]) begin
                    rem_next = rem_diff[CW-1:0];
                    dvd_next = {dvd_reg[SUM_WIDTH-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[CW-1:0];
                    dvd_next = {dvd_reg[SUM_WIDTH-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (!side_reg) begin
                    if (dvs_reg == '0) begin
                        neg_mean_next = '0;
                    end else if (dvd_reg >= NEG_MAG_LIMIT) begin
                        neg_mean_next = NEG_MEAN_MIN;
                    end else begin
                        neg_mean_next = '0 - dvd_reg[NEG_MEAN_WIDTH-1:0];
                    end
                    side_next  = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    if (dvs_reg == '0) begin
                        pos_mean_next = '0;
                    end else if (dvd_reg > SUM_WIDTH'(POS_MEAN_MAX)) begin
                        pos_mean_next = POS_MEAN_MAX;
                    end else begin
                        pos_mean_next = dvd_reg[POS_MEAN_WIDTH-1:0];
                    end
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {pos_mean_reg, neg_mean_reg, code_reg};
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b1;
                    pos_sum_next  = '0;
                    neg_sum_next  = '0;
                    pos_cnt_next  = '0;
                    neg_cnt_next  = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_sum_reg  <= '0;
            neg_sum_reg  <= '0;
            pos_cnt_reg  <= '0;
            neg_cnt_reg  <= '0;
            side_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_sum_reg  <= pos_sum_next;
            neg_sum_reg  <= neg_sum_next;
            pos_cnt_reg  <= pos_cnt_next;
            neg_cnt_reg  <= neg_cnt_next;
            side_reg     <= side_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        step_reg     <= step_next;
        code_reg     <= code_next;
        neg_mean_reg <= neg_mean_next;
        pos_mean_reg <= pos_mean_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/core/obq_port_chk.sv
// ----------------------------------------------------------------------------
// One-bit quantizer port checker
// Watches the result channel and the input ready of the quantizer core.
// ----------------------------------------------------------------------------
`include "one_bit_quantizer_mean_recon_assert.svh"

module obq_port_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [obq_pkg::TDATA_WIDTH-1:0] m_tdata,   // code, neg_mean, pos_mean
    input logic                            m_tuser,   // means_valid
    input logic                            m_tlast
);
    import obq_pkg::*;

    `OBQ_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `OBQ_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `OBQ_ASSERT(a_means_flag_on_last, aclk, aresetn, m_tvalid |-> (m_tuser == m_tlast), "means flag differs from last")

    `OBQ_ASSERT(a_plain_result_no_means, aclk, aresetn, m_tvalid && !m_tuser |-> (m_tdata[TDATA_WIDTH-1:NEG_MEAN_LSB] == '0), "means set on a plain result")

    `OBQ_ASSERT(a_no_request_while_stalled, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready, "request taken while result stalled")

endmodule

bind one_bit_quantizer_mean_recon obq_port_chk u_obq_port_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/one_bit_quantizer_mean_recon_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// One-bit quantizer mean reconstruction testbench
// Streams blocks of signed samples into the quantizer and checks every
// result (sign code, block-end means, flags) against an in-bench model of
// the running sums and counts, with random stalls on both channels.
// ----------------------------------------------------------------------------
module one_bit_quantizer_mean_recon_tb;
    import obq_pkg::*;

    localparam int     HALF_PERIOD  = 2;
    localparam int     SIDE_LIMIT   = DEF_MAX_LEN;
    localparam longint SUM_HI       = 64'sd2147483647;
    localparam longint SUM_LO       = -64'sd2147483648;
    localparam int     RANDOM_ITEMS = 480;
    localparam int     TAIL_ITEMS   = 40;
    localparam int     CYCLE_LIMIT  = 2_000_000;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     PRINT_LIMIT  = 50;
    localparam int     ROW_COUNT    = 21;

    typedef struct packed {
        logic                      code;
        logic                      means_valid;
        logic [NEG_MEAN_WIDTH-1:0] neg_mean;
        logic [POS_MEAN_WIDTH-1:0] pos_mean;
        logic                      last_out;
    } recon_result_t;

    typedef struct {
        logic [SAMPLE_IN_WIDTH-1:0] sample;
        logic                       last;
        bit                         typed;
        recon_result_t              result;
    } stim_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [SAMPLE_IN_WIDTH-1:0] s_tdata;   // sample
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [TDATA_WIDTH-1:0]     m_tdata;   // code, neg_mean, pos_mean
    logic                       m_tuser;   // means_valid
    logic                       m_tlast;

    // Running block state of the model
    longint pos_sum;
    longint neg_sum;
    int     pos_count;
    int     neg_count;

    recon_result_t expected_results[$];
    int  error_count;
    int  sample_count;
    int  block_count;
    int  checked_count;
    int  cycle_count;
    bit  idle_en;
    int  stall_left;

    // Directed requests; a typed result is written out where it is obvious
    stim_row_t directed_rows [0:ROW_COUNT-1] = '{
        '{16'h7FFF, 1'b1, 1'b1, '{1'b1, 1'b1, 16'h0000, 15'h7FFF, 1'b1}},
        '{16'h8000, 1'b1, 1'b1, '{1'b0, 1'b1, 16'h8000, 15'h0000, 1'b1}},
        '{16'h0000, 1'b1, 1'b1, '{1'b0, 1'b1, 16'h0000, 15'h0000, 1'b1}},
        '{16'h0001, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 15'h0000, 1'b0}},
        '{16'hFFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 15'h0000, 1'b0}},
        '{16'h0002, 1'b0, 1'b0, '0},
        '{16'hFFFC, 1'b1, 1'b0, '0},
        '{16'h0005, 1'b0, 1'b0, '0},
        '{16'h0006, 1'b0, 1'b0, '0},
        '{16'h0007, 1'b1, 1'b0, '0},
        '{16'hFFFD, 1'b0, 1'b0, '0},
        '{16'hFFFC, 1'b1, 1'b0, '0},
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b1, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b0, 1'b0, '0},
        '{16'h0001, 1'b1, 1'b0, '0},
        '{16'h5555, 1'b0, 1'b0, '0},
        '{16'hAAAA, 1'b1, 1'b0, '0}
    };

    one_bit_quantizer_mean_recon DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic longint clamp_sum(input longint value);
        if (value > SUM_HI) return SUM_HI;
        if (value < SUM_LO) return SUM_LO;
        return value;
    endfunction

    // Fold one sample into the block sums and return the result it causes
    function automatic recon_result_t quantize_and_average(
        input logic [SAMPLE_IN_WIDTH-1:0] sample,
        input logic                       last
    );
        longint        value;
        longint        neg_avg;
        longint        pos_avg;
        recon_result_t res;
        value = longint'($signed(sample));
        res = '0;
        res.means_valid = last;
        res.last_out = last;
        if (value > 0) begin
            res.code = 1'b1;
            if (pos_count < SIDE_LIMIT) begin
                pos_sum = clamp_sum(pos_sum + value);
                pos_count++;
            end
        end else begin
            res.code = 1'b0;
            if (neg_count < SIDE_LIMIT) begin
                neg_sum = clamp_sum(neg_sum + value);
                neg_count++;
            end
        end
        if (last) begin
            // empty side reads as zero; division truncates toward zero
            neg_avg = (neg_count == 0) ? 0 : neg_sum / longint'(neg_count);
            pos_avg = (pos_count == 0) ? 0 : pos_sum / longint'(pos_count);
            if (neg_avg < -32768) neg_avg = -32768;
            if (neg_avg > 0) neg_avg = 0;
            if (pos_avg < 0) pos_avg = 0;
            if (pos_avg > 32767) pos_avg = 32767;
            res.neg_mean = neg_avg[NEG_MEAN_WIDTH-1:0];
            res.pos_mean = pos_avg[POS_MEAN_WIDTH-1:0];
            pos_sum = 0;
            neg_sum = 0;
            pos_count = 0;
            neg_count = 0;
        end
        return res;
    endfunction

    function automatic logic [SAMPLE_IN_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return ($urandom_range(0, 1) != 0) ? 16'h0001 : 16'hFFFF;
            4, 5: return SAMPLE_IN_WIDTH'($urandom_range(0, 64)) - 16'd32;
            default: return SAMPLE_IN_WIDTH'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_sample(input logic [SAMPLE_IN_WIDTH-1:0] sample, input logic last,
                               input bit typed, input recon_result_t typed_res);
        int            gap;
        recon_result_t predicted;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predicted = quantize_and_average(sample, last);
        expected_results.push_back(typed ? typed_res : predicted);
        sample_count++;
        if (last) block_count++;
    endtask

    // Result side: random stall bursts while idling is on
    initial begin
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 15);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        recon_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", m_tdata, 32'h0);
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (m_tdata[CODE_BIT] !== want.code)
                    report_mismatch("code", 32'(m_tdata[CODE_BIT]), 32'(want.code));
                if (m_tuser !== want.means_valid)
                    report_mismatch("means_valid", 32'(m_tuser), 32'(want.means_valid));
                if (m_tdata[NEG_MEAN_MSB:NEG_MEAN_LSB] !== want.neg_mean)
                    report_mismatch("neg_mean", 32'(m_tdata[NEG_MEAN_MSB:NEG_MEAN_LSB]),
                                    32'(want.neg_mean));
                if (m_tdata[POS_MEAN_LSB +: POS_MEAN_WIDTH] !== want.pos_mean)
                    report_mismatch("pos_mean", 32'(m_tdata[POS_MEAN_LSB +: POS_MEAN_WIDTH]),
                                    32'(want.pos_mean));
                if (m_tlast !== want.last_out)
                    report_mismatch("last_out", 32'(m_tlast), 32'(want.last_out));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int block_len;
        int sent;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        error_count = 0;
        sample_count = 0;
        block_count = 0;
        checked_count = 0;
        cycle_count = 0;
        idle_en = 1'b1;
        pos_sum = 0;
        neg_sum = 0;
        pos_count = 0;
        neg_count = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < ROW_COUNT; i++)
            send_sample(directed_rows[i].sample, directed_rows[i].last,
                        directed_rows[i].typed, directed_rows[i].result);

        // Random blocks, mostly short, now and then a longer one
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            block_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60)
                                                    : $urandom_range(1, 16);
            for (int k = 0; k < block_len; k++)
                send_sample(pick_sample(), k == block_len - 1, 1'b0, '0);
            sent += block_len;
        end

        // Tail without idling: short blocks back to back
        idle_en = 1'b0;
        sent = 0;
        while (sent < TAIL_ITEMS) begin
            block_len = $urandom_range(1, 8);
            for (int k = 0; k < block_len; k++)
                send_sample(pick_sample(), k == block_len - 1, 1'b0, '0);
            sent += block_len;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples in %0d blocks, checked %0d results", sample_count,
                 block_count, checked_count);
        $display("Covered extremes, empty sides, stalls on both channels and gapless blocks");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
